[design/ibmt_pkg.sv]
// ============================================================================
// ibmt_pkg: shared definitions for the IP blacklist match table
// Field widths, command and status codes, and the default table depth.
// ============================================================================
package ibmt_pkg;

    // Default number of table slots
    localparam int DEFAULT_ENTRIES = 64;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int HALF_W   = 64;
    localparam int LIST_W   = 8;
    localparam int STATUS_W = 3;

    // Packed stream widths (tdata padded to whole bytes)
    localparam int S_DATA_W = 4 * HALF_W + LIST_W;
    localparam int S_USER_W = CMD_W;
    localparam int M_DATA_W = 2 * LIST_W;
    localparam int M_USER_W = STATUS_W;

    // Command codes; the fourth code is unused and dropped
    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_MATCH    = 3'd0,
        ST_INSERTED = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_ABSENT   = 3'd4,
        ST_FULL     = 3'd5,
        ST_BADLIST  = 3'd6
    } status_t;

endpackage

[design/ip_blacklist_match_table_unit.sv]
// ============================================================================
// ip_blacklist_match_table_unit: exact-match table of 128-bit IP addresses
// Associative table mapping addresses to nonzero blacklist numbers, with
// lookup of flow address pairs and add / update / remove of entries.
// ============================================================================
// Usage:
//   The slave stream carries one command per beat (tuser = cmd). A lookup
//   compares the source and destination addresses against every valid slot
//   in parallel and emits a report beat only if at least one address is
//   listed. Add and remove always emit one status beat; the unused command
//   code is dropped without a beat.
//   Throughput: one beat per cycle while the master side accepts, set by the
//   single compare-and-update stage between the input register and the
//   result register; the table update of one beat is visible to the next
//   beat in the following cycle. An accepted beat reaches the master side
//   via the input register and the result register (two register stages).
//   Reset clears all slot valid bits at once (table empty); keys and list
//   numbers are not cleared and no clearing pass is needed.
//   When the master side stalls, the result register holds its beat and the
//   input register can still take one more beat; after that tready drops.
// ============================================================================
module ip_blacklist_match_table_unit #(
    parameter int TABLE_ENTRIES = ibmt_pkg::DEFAULT_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Command stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [63:0] src_addr_hi, [127:64] src_addr_lo, [191:128] dst_addr_hi,
    // [255:192] dst_addr_lo, [263:256] new_list
    input  logic [ibmt_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [ibmt_pkg::S_USER_W-1:0] s_axis_tuser,
    // Result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] src_list, [15:8] dst_list
    output logic [ibmt_pkg::M_DATA_W-1:0] m_axis_tdata,
    // [2:0] status
    output logic [ibmt_pkg::M_USER_W-1:0] m_axis_tuser
);

    localparam int HW = ibmt_pkg::HALF_W;
    localparam int LW = ibmt_pkg::LIST_W;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                          in_valid_reg, in_valid_next;
    logic [ibmt_pkg::CMD_W-1:0]    cmd_reg;
    logic [HW-1:0]                 src_hi_reg, src_lo_reg, dst_hi_reg, dst_lo_reg;
    logic [LW-1:0]                 new_list_reg;

    logic out_free, work_fire, in_accept;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign work_fire     = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (work_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload capture, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg      <= s_axis_tuser[ibmt_pkg::CMD_W-1:0];
            src_hi_reg   <= s_axis_tdata[HW-1:0];
            src_lo_reg   <= s_axis_tdata[2*HW-1:HW];
            dst_hi_reg   <= s_axis_tdata[3*HW-1:2*HW];
            dst_lo_reg   <= s_axis_tdata[4*HW-1:3*HW];
            new_list_reg <= s_axis_tdata[4*HW+LW-1:4*HW];
        end
    end

    // ------------------------------------------------------------------
    // Slot storage
    // ------------------------------------------------------------------
    logic [TABLE_ENTRIES-1:0] slot_valid_reg, slot_valid_next;
    logic [HW-1:0]            slot_key_hi_reg [TABLE_ENTRIES];
    logic [HW-1:0]            slot_key_lo_reg [TABLE_ENTRIES];
    logic [LW-1:0]            slot_list_reg   [TABLE_ENTRIES];

    // ------------------------------------------------------------------
    // Parallel compare against every slot
    // ------------------------------------------------------------------
    logic [TABLE_ENTRIES-1:0] src_hit, dst_hit;
    logic [LW-1:0]            src_list_sel, dst_list_sel;
    logic                     src_any, dst_any;

    always_comb
    begin
        src_list_sel = '0;
        dst_list_sel = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            src_hit[i] = slot_valid_reg[i] && (slot_key_hi_reg[i] == src_hi_reg)
                         && (slot_key_lo_reg[i] == src_lo_reg);
            dst_hit[i] = slot_valid_reg[i] && (slot_key_hi_reg[i] == dst_hi_reg)
                         && (slot_key_lo_reg[i] == dst_lo_reg);
            // keys are unique, so at most one slot contributes
            src_list_sel = src_list_sel | (slot_list_reg[i] & {LW{src_hit[i]}});
            dst_list_sel = dst_list_sel | (slot_list_reg[i] & {LW{dst_hit[i]}});
        end
    end

    assign src_any = |src_hit;
    assign dst_any = |dst_hit;

    // lowest free slot as a one-hot vector
    logic [TABLE_ENTRIES-1:0] free_vec, free_onehot;
    logic                     table_full;

    assign free_vec    = ~slot_valid_reg;
    assign free_onehot = free_vec & (~free_vec + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1});
    assign table_full  = ~|free_vec;

    // ------------------------------------------------------------------
    // Command decode
    // ------------------------------------------------------------------
    logic               do_insert, do_update, do_remove;
    logic               emit;
    ibmt_pkg::status_t  status_w;
    logic [LW-1:0]      res_src, res_dst;

    always_comb
    begin
        do_insert = 1'b0;
        do_update = 1'b0;
        do_remove = 1'b0;
        emit      = 1'b0;
        status_w  = ibmt_pkg::ST_MATCH;
        res_src   = '0;
        res_dst   = '0;
        case (cmd_reg)
            ibmt_pkg::CMD_LOOKUP:
            begin
                emit    = src_any || dst_any;
                res_src = src_list_sel;
                res_dst = dst_list_sel;
            end
            ibmt_pkg::CMD_ADD:
            begin
                emit = 1'b1;
                if (new_list_reg == '0)
                begin
                    status_w = ibmt_pkg::ST_BADLIST;
                end
                else if (src_any)
                begin
                    do_update = 1'b1;
                    status_w  = ibmt_pkg::ST_UPDATED;
                end
                else if (table_full)
                begin
                    status_w = ibmt_pkg::ST_FULL;
                end
                else
                begin
                    do_insert = 1'b1;
                    status_w  = ibmt_pkg::ST_INSERTED;
                end
            end
            ibmt_pkg::CMD_REMOVE:
            begin
                emit = 1'b1;
                if (src_any)
                begin
                    do_remove = 1'b1;
                    status_w  = ibmt_pkg::ST_REMOVED;
                end
                else
                begin
                    status_w = ibmt_pkg::ST_ABSENT;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Table update
    // ------------------------------------------------------------------
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (work_fire && do_insert)
        begin
            slot_valid_next = slot_valid_reg | free_onehot;
        end
        else if (work_fire && do_remove)
        begin
            slot_valid_next = slot_valid_reg & ~src_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
        end
    end

    // slot payload, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (work_fire && do_insert && free_onehot[i])
            begin
                slot_key_hi_reg[i] <= src_hi_reg;
                slot_key_lo_reg[i] <= src_lo_reg;
                slot_list_reg[i]   <= new_list_reg;
            end
            else if (work_fire && do_update && src_hit[i])
            begin
                slot_list_reg[i] <= new_list_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic               out_valid_reg, out_valid_next;
    ibmt_pkg::status_t  out_status_reg;
    logic [LW-1:0]      out_src_list_reg, out_dst_list_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (work_fire)
        begin
            out_valid_next = emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_fire && emit)
        begin
            out_status_reg   <= status_w;
            out_src_list_reg <= res_src;
            out_dst_list_reg <= res_dst;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = ibmt_pkg::M_USER_W'(out_status_reg);
    assign m_axis_tdata  = {out_dst_list_reg, out_src_list_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // keys stay unique among valid slots
    a_src_unique : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(src_hit))
        else $error("source key matches more than one slot");

    a_dst_unique : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(dst_hit))
        else $error("destination key matches more than one slot");

    // a stalled input side means both register stages are occupied
    a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // a rejected list number leaves the table untouched
    a_badlist_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (work_fire && (cmd_reg == ibmt_pkg::CMD_ADD) && (new_list_reg == '0))
        |=> (slot_valid_reg == $past(slot_valid_reg)))
        else $error("bad list number changed the table");

    // a successful insert takes exactly one more slot
    a_insert_count : assert property (@(posedge clk) disable iff (!rst_n)
        (work_fire && do_insert)
        |=> ($countones(slot_valid_reg) == $past($countones(slot_valid_reg)) + 1))
        else $error("insert did not fill exactly one slot");

endmodule
